// ----- rtl/core/fragment_reassembly_tracker_macros.svh -----
// Assertion macros for the fragment reassembly tracker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frt: same-cycle check failed");
// next-cycle implication
`define FRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frt: next-cycle check failed");
`else
`define FRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/frt_pkg.sv -----
// Shared types and constants of the fragment reassembly tracker.
// No dependencies.
package frt_pkg;

	// reset value of the max_payload register
	localparam logic [15:0] MP_RESET = 16'd512;

	// width of MAX_FRAGMENTS * max_payload, sized for MAX_FRAGMENTS up to 4096
	localparam int unsigned LIM_W = 28;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_BYPASS   = 3'd2,
		ST_FULL     = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	// classified fragment header handed from front to back
	typedef struct packed {
		logic [15:0]      sender;
		logic [63:0]      msg_addr;
		logic [9:0]       frag_idx;
		logic [25:0]      total_bytes;
		logic             bypass;
		logic [15:0]      mp;       // effective max_payload (zero read as one)
		logic [25:0]      offset;   // frag_idx * mp
		logic [LIM_W-1:0] limit;    // MAX_FRAGMENTS * mp
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  entry;
		logic [25:0] slot_offset;
		logic [25:0] msg_bytes;
	} result_t;

endpackage

// ----- rtl/core/frt_intf.sv -----
// Handshake interfaces of the fragment reassembly tracker: fragment headers in,
// tracking results out. No dependencies.
interface frt_frag_if;
	logic        valid;
	logic        ready;
	logic [15:0] sender;
	logic [63:0] msg_addr;
	logic [9:0]  frag_idx;
	logic [15:0] frag_bytes;
	logic [25:0] total_bytes;

	modport source (output valid, sender, msg_addr, frag_idx, frag_bytes, total_bytes,
		input ready);
	modport sink (input valid, sender, msg_addr, frag_idx, frag_bytes, total_bytes,
		output ready);
endinterface

interface frt_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  entry;
	logic [25:0] slot_offset;
	logic [25:0] msg_bytes;

	modport source (output valid, status, entry, slot_offset, msg_bytes, input ready);
	modport sink (input valid, status, entry, slot_offset, msg_bytes, output ready);
endinterface

// ----- rtl/core/frt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frt_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/frt_fifo.sv -----
// Two-entry item queue between the front and back parts.
// Depends on frt_pkg.
module frt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  frt_pkg::item_t push_item,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output frt_pkg::item_t head
);

	frt_pkg::item_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/core/frt_front.sv -----
// Front part: holds max_payload, accepts fragment headers, flags single-fragment
// messages and precomputes the slot offset and range limit. Depends on frt_pkg, frt_intf.
module frt_front #(
	parameter int unsigned MAX_FRAGMENTS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	frt_frag_if.sink       frag,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  logic           init_busy,
	output logic           push_valid,
	input  logic           push_ready,
	output frt_pkg::item_t push_item
);

	localparam int unsigned LW = frt_pkg::LIM_W;

	logic [15:0]    mp_q;
	logic [15:0]    mp_eff;
	logic           v_s1;
	frt_pkg::item_t item_s1;
	logic           take;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_q <= frt_pkg::MP_RESET;
		end else if (cfg_we) begin
			mp_q <= cfg_wdata;
		end
	end

	assign mp_eff     = (mp_q == 16'd0) ? 16'd1 : mp_q;
	assign frag.ready = (!v_s1 || push_ready) && !init_busy;
	assign take       = frag.valid && frag.ready;
	assign push_valid = v_s1;
	assign push_item  = item_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// classify and precompute products
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.sender      <= frag.sender;
			item_s1.msg_addr    <= frag.msg_addr;
			item_s1.frag_idx    <= frag.frag_idx;
			item_s1.total_bytes <= frag.total_bytes;
			item_s1.bypass      <= (26'(frag.frag_bytes) == frag.total_bytes);
			item_s1.mp          <= mp_eff;
			item_s1.offset      <= 26'(frag.frag_idx) * 26'(mp_eff);
			item_s1.limit       <= LW'(MAX_FRAGMENTS) * LW'(mp_eff);
		end
	end

endmodule

// ----- rtl/core/frt_back.sv -----
// Back part: open-message table, fragment mark memory and result register.
// Depends on frt_pkg, frt_intf, frt_ram and the assertion macro header.
`include "fragment_reassembly_tracker_macros.svh"

module frt_back #(
	parameter int unsigned TABLE_ENTRIES = 16,
	parameter int unsigned MAX_FRAGMENTS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  frt_pkg::item_t head,
	output logic           pop,
	output logic           init_busy,
	frt_result_if.source   result
);

	localparam int unsigned EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned FW    = $clog2(MAX_FRAGMENTS);
	localparam int unsigned AW    = EW + FW;
	localparam int unsigned DEPTH = 2 ** AW;
	localparam int unsigned CW    = $clog2(MAX_FRAGMENTS + 1);
	localparam int unsigned PW    = CW + 16;
	localparam int unsigned LW    = frt_pkg::LIM_W;
	localparam logic [FW-1:0] SW_LAST = FW'(MAX_FRAGMENTS - 1);

	typedef enum logic [7:0] {
		S_INIT  = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_CMP   = 8'b0000_0100,
		S_DEC   = 8'b0000_1000,
		S_READ  = 8'b0001_0000,
		S_CHK   = 8'b0010_0000,
		S_OUT   = 8'b0100_0000,
		S_SWEEP = 8'b1000_0000
	} state_t;

	state_t state_q;

	// open-message table
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [15:0]              sender_q [TABLE_ENTRIES];
	logic [63:0]              tag_q    [TABLE_ENTRIES];
	logic [25:0]              total_q  [TABLE_ENTRIES];
	logic [15:0]              mpa_q    [TABLE_ENTRIES];
	logic [CW-1:0]            cnt_q    [TABLE_ENTRIES];

	frt_pkg::item_t           item_q;
	frt_pkg::result_t         res_q;
	frt_pkg::result_t         out_q;
	logic                     out_v_q;
	logic                     sweep_q;
	logic [TABLE_ENTRIES-1:0] hit_q;
	logic [TABLE_ENTRIES-1:0] free_q;
	logic [EW-1:0]            idx_q;
	logic                     new_q;
	logic [AW-1:0]            init_cnt_q;
	logic [FW-1:0]            sw_q;

	logic          hit_any;
	logic          free_any;
	logic [EW-1:0] hit_idx;
	logic [EW-1:0] free_idx;
	logic [EW-1:0] dec_idx;
	logic [FW-1:0] fidx;
	logic [25:0]   etot;
	logic          range_bad;
	logic [CW-1:0] cnt_base;
	logic [CW-1:0] cnt_n;
	logic [PW-1:0] prod;
	logic [25:0]   chk_tot;
	logic          chk_done;
	logic          out_load;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [0:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [0:0]    ram_rdata;

	assign init_busy = (state_q == S_INIT);
	assign pop       = (state_q == S_IDLE) && pop_valid;
	assign out_load  = (state_q == S_OUT) && (!out_v_q || result.ready);

	// lowest matching and lowest free entry
	always_comb begin
		hit_any  = |hit_q;
		free_any = |free_q;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				hit_idx = EW'(i);
			end
			if (free_q[i]) begin
				free_idx = EW'(i);
			end
		end
	end

	// range check: frag_idx >= ceil(t/mp) is frag_idx*mp >= t,
	// and a count above MAX_FRAGMENTS is t > MAX_FRAGMENTS*mp
	assign dec_idx   = hit_any ? hit_idx : free_idx;
	assign fidx      = FW'(item_q.frag_idx);
	assign etot      = hit_any ? total_q[hit_idx] : item_q.total_bytes;
	assign range_bad = (LW'(etot) > item_q.limit) ||
		((etot == 26'd0) ? (item_q.frag_idx != 10'd0) : (item_q.offset >= etot));

	// mark update and completion test (count*mp >= total, empty message needs one)
	assign cnt_base = new_q ? '0 : cnt_q[idx_q];
	assign cnt_n    = cnt_base + CW'(!ram_rdata[0]);
	assign prod     = PW'(cnt_q[idx_q]) * PW'(mpa_q[idx_q]);
	assign chk_tot  = total_q[idx_q];
	assign chk_done = (chk_tot == 26'd0) ? (cnt_q[idx_q] != '0) : (32'(prod) >= 32'(chk_tot));

	// mark memory ports
	assign ram_raddr = {dec_idx, fidx};
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		ram_waddr = {idx_q, fidx};
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_cnt_q;
			end
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = {idx_q, sw_q};
			end
			S_READ: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	frt_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_marks (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_cnt_q <= '0;
			sw_q       <= '0;
			valid_q    <= '0;
			out_v_q    <= 1'b0;
			sweep_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (&init_cnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					sweep_q <= 1'b0;
					if (pop_valid) begin
						state_q <= head.bypass ? S_OUT : S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= (range_bad || (!hit_any && !free_any)) ? S_OUT : S_READ;
				end
				S_READ: begin
					if (new_q) begin
						valid_q[idx_q] <= 1'b1;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (chk_done) begin
						valid_q[idx_q] <= 1'b0;
					end
					sweep_q <= chk_done;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						sw_q    <= '0;
						state_q <= sweep_q ? S_SWEEP : S_IDLE;
					end
				end
				S_SWEEP: begin
					sw_q <= sw_q + 1'b1;
					if (sw_q == SW_LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q            <= head;
				res_q.status      <= frt_pkg::ST_BYPASS;
				res_q.entry       <= 4'd0;
				res_q.slot_offset <= 26'd0;
				res_q.msg_bytes   <= head.total_bytes;
			end
			S_CMP: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					hit_q[i]  <= valid_q[i] && (sender_q[i] == item_q.sender) &&
						(tag_q[i] == item_q.msg_addr);
					free_q[i] <= !valid_q[i];
				end
			end
			S_DEC: begin
				idx_q             <= dec_idx;
				new_q             <= !hit_any;
				res_q.status      <= range_bad ? frt_pkg::ST_RANGE : frt_pkg::ST_FULL;
				res_q.entry       <= (range_bad && hit_any) ? 4'(hit_idx) : 4'd0;
				res_q.slot_offset <= 26'd0;
				res_q.msg_bytes   <= 26'd0;
			end
			S_READ: begin
				if (new_q) begin
					sender_q[idx_q] <= item_q.sender;
					tag_q[idx_q]    <= item_q.msg_addr;
					total_q[idx_q]  <= item_q.total_bytes;
					mpa_q[idx_q]    <= item_q.mp;
				end
				cnt_q[idx_q] <= cnt_n;
			end
			S_CHK: begin
				res_q.status      <= chk_done ? frt_pkg::ST_COMPLETE : frt_pkg::ST_PENDING;
				res_q.entry       <= 4'(idx_q);
				res_q.slot_offset <= item_q.offset;
				res_q.msg_bytes   <= chk_done ? chk_tot : 26'd0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// output register
	assign result.valid       = out_v_q;
	assign result.status      = out_q.status;
	assign result.entry       = out_q.entry;
	assign result.slot_offset = out_q.slot_offset;
	assign result.msg_bytes   = out_q.msg_bytes;

	// checks
	`FRT_ASSERT_NEXT(a_free_on_done, clk, arst_n, (state_q == S_CHK) && chk_done, !valid_q[idx_q])
	`FRT_ASSERT_IMP(a_sweep_free, clk, arst_n, state_q == S_SWEEP, !valid_q[idx_q])
	`FRT_ASSERT_IMP(a_mark_set_read, clk, arst_n, ram_we && ram_wdata[0], state_q == S_READ)
	`FRT_ASSERT_IMP(a_no_pop_init, clk, arst_n, init_busy, !pop)

endmodule

// ----- rtl/core/fragment_reassembly_tracker.sv -----
// Fragment reassembly tracker top level: front, item queue and back part.
// Depends on frt_pkg, frt_intf, frt_front, frt_fifo, frt_back.
//
//  port       dir   handshake        carries
//  frag       in    valid/ready      fragment header
//  result     out   valid/ready      status, entry, slot offset, message bytes
//  cfg        in    cfg_we           max_payload write
//
// Single-fragment messages go from the back part's idle state straight to output
// load. A tracked fragment passes compare, decide, mark read, count check and
// output load (a rejected one skips read and check); no new fragment is taken
// before it is through, which sets the sustained rate. Completing a message adds
// a sweep that clears its marks. After reset the mark memory is cleared, one bit
// a cycle: 2**(clog2(TABLE_ENTRIES)+clog2(MAX_FRAGMENTS)) bits (16384 at the
// defaults), with frag.ready low. The queue takes items while a result waits.
module fragment_reassembly_tracker #(
	parameter int unsigned TABLE_ENTRIES = 16,
	parameter int unsigned MAX_FRAGMENTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	frt_frag_if.sink      frag,
	frt_result_if.source  result,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);

	logic           init_busy;
	logic           push_valid;
	logic           push_ready;
	frt_pkg::item_t push_item;
	logic           pop;
	logic           pop_valid;
	frt_pkg::item_t head;

	frt_front #(
		.MAX_FRAGMENTS(MAX_FRAGMENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frag      (frag),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.init_busy (init_busy),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	frt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid && push_ready),
		.push_item(push_item),
		.not_full (push_ready),
		.pop      (pop),
		.not_empty(pop_valid),
		.head     (head)
	);

	frt_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_FRAGMENTS(MAX_FRAGMENTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.head     (head),
		.pop      (pop),
		.init_busy(init_busy),
		.result   (result)
	);

endmodule
